>>> rtl/core/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Shared types, constants and helpers for the four-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    // Word memory geometry.
    localparam int MEM_ADDR_BITS   = 13;
    localparam int MEM_DEPTH       = 1 << MEM_ADDR_BITS;

    // Field widths of the item and result transfers.
    localparam int WORD_INDEX_BITS = 13;
    localparam int WORD_BITS       = 64;
    localparam int ROOT_BITS       = 16;
    localparam int VADDR_BITS      = 48;
    localparam int LEVEL_BITS      = 2;

    // Address translation geometry.
    localparam int PAGE_BITS       = 12;
    localparam int IDX_BITS        = 9;
    localparam int ENTRY_SHIFT     = 3;
    localparam int VIDX_BITS       = VADDR_BITS - PAGE_BITS;

    // Item kinds.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_WALK  = 1'b1;

    typedef struct packed {
        logic                       action;
        logic [WORD_INDEX_BITS-1:0] word_index;
        logic [WORD_BITS-1:0]       write_word;
        logic [ROOT_BITS-1:0]       root_addr;
        logic [VADDR_BITS-1:0]      virt_addr;
        logic [LEVEL_BITS-1:0]      walk_level;
    } t_in_item;

    typedef struct packed {
        logic                 walk_ok;
        logic [WORD_BITS-1:0] entry_addr;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the incoming item, write memory for a write item
        logic rd_cur;    // read the entry at the current address
        logic step;      // advance to the next level using the read entry
        logic rd_next;   // read the entry at the next level address
        logic fail;      // entry not present, clear the result
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_item;  // incoming item needs no memory read
        logic present;     // present bit of the entry just read
        logic last;        // next level is the wanted one
    } t_dp_sts;

    // Nine-bit table index of one level taken from virtual address bits 47:12.
    function automatic logic [IDX_BITS-1:0] level_index(
        input logic [VIDX_BITS-1:0]  vidx,
        input logic [LEVEL_BITS-1:0] lvl
    );
        logic [IDX_BITS-1:0] idx;
        case (lvl)
            2'd0:    idx = vidx[4*IDX_BITS-1:3*IDX_BITS];
            2'd1:    idx = vidx[3*IDX_BITS-1:2*IDX_BITS];
            2'd2:    idx = vidx[2*IDX_BITS-1:IDX_BITS];
            default: idx = vidx[IDX_BITS-1:0];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ptw_ctrl.sv
// ----------------------------------------------------------------------------
// Page table walker controller
// State machine that sequences item intake, entry reads and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ctrl
    import ptw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   slot_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.short_item ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (!i_sts.present) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.last) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.step    = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Only one item is in flight: intake closes right after a transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("ptw_ctrl: intake still open after an item transfer");

    // Entry data is only checked after a read was issued in the cycle before.
    a_read_before_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(o_cmd.rd_cur || o_cmd.rd_next))
        else $error("ptw_ctrl: entry checked without a preceding read");

    // A result loaded into the output register is offered the next cycle.
    a_result_offered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("ptw_ctrl: loaded result not offered");

endmodule

`default_nettype wire

>>> rtl/core/ptw_dpath.sv
// ----------------------------------------------------------------------------
// Page table walker datapath
// Table memory, walk address and level registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_dpath
    import ptw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_in_item i_in_data,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_sts       o_sts,
    output t_out_item     o_out_data
);

    logic [WORD_BITS-1:0]  mem [MEM_DEPTH];

    logic [WORD_BITS-1:0]  r_addr;
    logic [VIDX_BITS-1:0]  r_vidx;
    logic [LEVEL_BITS-1:0] r_lvl;
    logic [LEVEL_BITS-1:0] r_target;
    logic                  r_ok;
    logic [WORD_BITS-1:0]  r_rdata;
    t_out_item             r_out;

    logic [LEVEL_BITS-1:0]                   lvl_inc;
    logic [WORD_BITS-1:0]                    addr0;
    logic [WORD_BITS-1:0]                    next_addr;
    logic [MEM_ADDR_BITS+WORD_INDEX_BITS-1:0] widx_wide;
    logic [MEM_ADDR_BITS-1:0]                waddr;
    logic [MEM_ADDR_BITS-1:0]                raddr;
    logic                                    mem_we;
    logic                                    mem_re;

    assign lvl_inc = r_lvl + LEVEL_BITS'(1);

    // Top level entry: root plus eight times the index from bits 47:39.
    assign addr0 = WORD_BITS'(i_in_data.root_addr)
                 + WORD_BITS'({level_index(i_in_data.virt_addr[VADDR_BITS-1:PAGE_BITS],
                                           LEVEL_BITS'(0)),
                               ENTRY_SHIFT'(0)});

    // The entry's low twelve bits are replaced by the scaled index, which fits in them.
    assign next_addr = {r_rdata[WORD_BITS-1:PAGE_BITS],
                        level_index(r_vidx, lvl_inc),
                        ENTRY_SHIFT'(0)};

    assign widx_wide = {{MEM_ADDR_BITS{1'b0}}, i_in_data.word_index};
    assign waddr     = widx_wide[MEM_ADDR_BITS-1:0];
    assign raddr     = i_cmd.rd_next ? next_addr[ENTRY_SHIFT +: MEM_ADDR_BITS]
                                     : r_addr[ENTRY_SHIFT +: MEM_ADDR_BITS];
    assign mem_we    = i_cmd.load && (i_in_data.action == ACT_WRITE);
    assign mem_re    = i_cmd.rd_cur || i_cmd.rd_next;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= i_in_data.write_word;
        end
        if (mem_re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vidx   <= i_in_data.virt_addr[VADDR_BITS-1:PAGE_BITS];
            r_target <= i_in_data.walk_level;
            r_lvl    <= '0;
            r_ok     <= 1'b1;
            r_addr   <= (i_in_data.action == ACT_WRITE) ? '0 : addr0;
        end else if (i_cmd.fail) begin
            r_ok   <= 1'b0;
            r_addr <= '0;
        end else if (i_cmd.step) begin
            r_lvl  <= lvl_inc;
            r_addr <= next_addr;
        end
        if (i_cmd.out_load) begin
            r_out.walk_ok    <= r_ok;
            r_out.entry_addr <= r_addr;
        end
    end

    assign o_sts.short_item = (i_in_data.action == ACT_WRITE) || (i_in_data.walk_level == '0);
    assign o_sts.present    = r_rdata[0];
    assign o_sts.last       = (lvl_inc == r_target);
    assign o_out_data       = r_out;

endmodule

`default_nettype wire

>>> rtl/core/four_level_page_table_walker_top.sv
// Walk: a write item or a level-0 walk needs no table read; a walk to level L (1 to 3)
// makes one dependent table memory read per level, and a failed walk finishes sooner.
// A new item is taken only once the previous result has moved into the result register.
// Reset: synchronous, active low; it clears the controller and output valid only.
// The table memory is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// Four-level page table walker
// Walks x86_64 style four-level page tables held in a private word memory.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_top
    import ptw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    // The controller decides when items are taken, when table entries are read
    // and when the result register is loaded. The datapath owns the table
    // memory, the running entry address and the result register.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // A write item stores its word in the transfer cycle and reports success
    // with a zero address. A walk item computes the top level entry address in
    // its transfer cycle, then reads one entry per level. Each read returns in
    // the following cycle, and the next address is formed directly from the
    // read entry so the next read can be issued in that same cycle.
    ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // The result register lets a finished result wait for its transfer while
    // the next item is already taken in.
    ptw_dpath u_dpath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
